FILE: design/afns_pkg.sv
// shared types and constants of the aspect-fit nearest-neighbour scaler
`default_nettype none
package afns_pkg;
    localparam int MAX_PIXELS      = 262144;
    localparam int MAX_DIM         = 4096;
    localparam int SCALE_FRAC_BITS = 16;
    localparam int ADDR_W          = $clog2(MAX_PIXELS);
    localparam int DIM_W           = $clog2(MAX_DIM) + 1;
    localparam int POS_W           = $clog2(MAX_DIM);
    localparam int CNT_W           = $clog2(MAX_PIXELS) + 1;
    localparam int DIV_W           = 32;

    localparam logic [2:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_CHANNELS   = 3'd2;
    localparam logic [2:0] CFG_LIMIT_X    = 3'd3;
    localparam logic [2:0] CFG_LIMIT_Y    = 3'd4;
    localparam logic [2:0] CFG_FIT_MODE   = 3'd5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_PIXEL     = 2'd0,
        ST_NO_SCALE  = 2'd1,
        ST_BAD_CHAN  = 2'd2,
        ST_NOT_READY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        DIV_RX = 2'd0,
        DIV_RY = 2'd1,
        DIV_OW = 2'd2,
        DIV_OH = 2'd3
    } div_op_t;

    typedef struct packed {
        logic    load_we;
        logic    div_start;
        div_op_t div_op;
        logic    out_load;
    } afns_cmd_t;

    typedef struct packed {
        logic geom_ok;
        logic frame_ready;
        logic load_room;
        logic load_last;
        logic div_done;
        logic out_free;
    } afns_stat_t;
endpackage
`default_nettype wire

FILE: design/afns_datapath.sv
// frame store, shared serial divider, read address pipeline and output register
`default_nettype none
module afns_datapath (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_addr,
    input  wire logic [12:0]           cfg_data,
    input  wire logic [31:0]           pixel_in,
    input  wire afns_pkg::afns_cmd_t   cmd,
    output afns_pkg::afns_stat_t       stat,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [87:0]                m_tdata,
    output logic                       m_tlast,
    output logic [1:0]                 m_tuser
);
    import afns_pkg::*;

    logic [DIM_W-1:0] width_reg, height_reg, limx_reg, limy_reg;
    logic [2:0]       chan_reg;
    logic             cover_reg;

    logic [CNT_W-1:0] load_cnt_reg;
    logic             ready_reg;
    logic [DIV_W-1:0] rx_reg, scale_reg;
    logic [DIM_W-1:0] ow_reg, oh_reg;
    logic [POS_W-1:0] col_reg;
    logic [DIM_W-1:0] row_reg;

    logic [31:0] mem [MAX_PIXELS];

    // divider
    logic             dv_busy_reg, dv_done_reg;
    logic [5:0]       dv_cnt_reg;
    logic [DIV_W-1:0] dv_rem_reg, dv_quo_reg, dv_dvs_reg;
    logic [DIV_W-1:0] dv_num, dv_den;
    logic [DIV_W:0]   dv_trial;
    div_op_t          dv_op_reg;

    // read pipeline
    logic [27:0]       cl_lo_reg, cl_hi_reg, rw_lo_reg, rw_hi_reg;
    logic [POS_W-1:0]  sx_reg, sy_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [31:0]       rd_data_reg;

    logic [2*DIM_W-1:0] total;
    logic               geom_ok, no_scale;
    logic [DIV_W-1:0]   rx_ext, sel_s, cx, cy;
    logic [DIM_W-1:0]   q_clamp;
    logic [2*DIM_W-1:0] idx_full;
    status_t            st;
    logic               last;
    logic               out_valid_reg;

    assign total   = width_reg * height_reg;
    assign geom_ok = (width_reg != '0) && (height_reg != '0) && (limx_reg != '0) &&
                     (limy_reg != '0) && (width_reg <= DIM_W'(MAX_DIM)) &&
                     (height_reg <= DIM_W'(MAX_DIM)) && (limx_reg <= DIM_W'(MAX_DIM)) &&
                     (limy_reg <= DIM_W'(MAX_DIM)) && (total <= (2*DIM_W)'(MAX_PIXELS));
    assign no_scale = cover_reg ? ((limx_reg < width_reg) && (limy_reg < height_reg))
                                : ((limx_reg > width_reg) && (limy_reg > height_reg));

    assign stat.geom_ok     = geom_ok;
    assign stat.frame_ready = ready_reg;
    assign stat.load_room   = (2*DIM_W)'(load_cnt_reg) < total;
    assign stat.load_last   = (2*DIM_W)'(load_cnt_reg) + 1'b1 == total;
    assign stat.div_done    = dv_done_reg;
    assign stat.out_free    = !out_valid_reg || m_tready;

    // divider operands
    always_comb begin
        dv_num = '0;
        dv_den = '0;
        case (cmd.div_op)
            DIV_RX: begin
                dv_num = DIV_W'({width_reg, SCALE_FRAC_BITS'(0)});
                dv_den = DIV_W'(limx_reg);
            end
            DIV_RY: begin
                dv_num = DIV_W'({height_reg, SCALE_FRAC_BITS'(0)});
                dv_den = DIV_W'(limy_reg);
            end
            DIV_OW: begin
                dv_num = DIV_W'({width_reg, SCALE_FRAC_BITS'(0)}) +
                         (cover_reg ? scale_reg - 1'b1 : '0);
                dv_den = scale_reg;
            end
            DIV_OH: begin
                dv_num = DIV_W'({height_reg, SCALE_FRAC_BITS'(0)}) +
                         (cover_reg ? scale_reg - 1'b1 : '0);
                dv_den = scale_reg;
            end
            default: ;
        endcase
    end

    assign dv_trial = {dv_rem_reg, dv_quo_reg[DIV_W-1]} - {1'b0, dv_dvs_reg};
    assign rx_ext   = rx_reg;
    always_comb begin
        if (cover_reg) begin
            sel_s = (rx_ext < dv_quo_reg) ? rx_ext : dv_quo_reg;
        end else begin
            sel_s = (rx_ext > dv_quo_reg) ? rx_ext : dv_quo_reg;
        end
        if (sel_s == '0) begin
            sel_s = DIV_W'(1);
        end
    end
    assign q_clamp = (dv_quo_reg > DIV_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dv_quo_reg[DIM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_busy_reg <= 1'b0;
            dv_done_reg <= 1'b0;
            dv_cnt_reg  <= '0;
        end else begin
            dv_done_reg <= 1'b0;
            if (cmd.div_start) begin
                dv_busy_reg <= 1'b1;
                dv_cnt_reg  <= 6'(DIV_W);
            end else if (dv_busy_reg) begin
                dv_cnt_reg <= dv_cnt_reg - 1'b1;
                if (dv_cnt_reg == 6'd1) begin
                    dv_busy_reg <= 1'b0;
                    dv_done_reg <= 1'b1;
                end
            end
        end
        if (cmd.div_start) begin
            dv_rem_reg <= '0;
            dv_quo_reg <= dv_num;
            dv_dvs_reg <= dv_den;
            dv_op_reg  <= cmd.div_op;
        end else if (dv_busy_reg) begin
            if (!dv_trial[DIV_W]) begin
                dv_rem_reg <= dv_trial[DIV_W-1:0];
            end else begin
                dv_rem_reg <= {dv_rem_reg[DIV_W-2:0], dv_quo_reg[DIV_W-1]};
            end
            dv_quo_reg <= {dv_quo_reg[DIV_W-2:0], !dv_trial[DIV_W]};
        end
    end

    // source coordinate pipeline: partial products, sum and clamp, address, store read
    assign cx = DIV_W'(cl_hi_reg) + DIV_W'(cl_lo_reg[27:SCALE_FRAC_BITS]);
    assign cy = DIV_W'(rw_hi_reg) + DIV_W'(rw_lo_reg[27:SCALE_FRAC_BITS]);
    assign idx_full = sy_reg * width_reg + (2*DIM_W)'(sx_reg);

    always_ff @(posedge aclk) begin
        cl_lo_reg <= col_reg * scale_reg[15:0];
        cl_hi_reg <= col_reg * scale_reg[31:16];
        rw_lo_reg <= row_reg[POS_W-1:0] * scale_reg[15:0];
        rw_hi_reg <= row_reg[POS_W-1:0] * scale_reg[31:16];
        sx_reg <= (cx >= DIV_W'(width_reg))  ? POS_W'(width_reg - 1'b1)  : cx[POS_W-1:0];
        sy_reg <= (cy >= DIV_W'(height_reg)) ? POS_W'(height_reg - 1'b1) : cy[POS_W-1:0];
        idx_reg <= idx_full[ADDR_W-1:0];
        rd_data_reg <= mem[idx_reg];
        if (cmd.load_we) begin
            mem[load_cnt_reg[ADDR_W-1:0]] <= pixel_in;
        end
    end

    always_comb begin
        if (!ready_reg || !geom_ok) begin
            st = ST_NOT_READY;
        end else if (chan_reg != 3'd3 && chan_reg != 3'd4) begin
            st = ST_BAD_CHAN;
        end else if (no_scale) begin
            st = ST_NO_SCALE;
        end else if (ow_reg == '0 || oh_reg == '0 || row_reg >= oh_reg) begin
            st = ST_NOT_READY;
        end else begin
            st = ST_PIXEL;
        end
    end
    assign last = (DIM_W'(col_reg) + 1'b1 == ow_reg) && (row_reg + 1'b1 == oh_reg);

    // configuration, frame state and emit position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= DIM_W'(512);
            height_reg   <= DIM_W'(512);
            chan_reg     <= 3'd4;
            limx_reg     <= DIM_W'(256);
            limy_reg     <= DIM_W'(256);
            cover_reg    <= 1'b0;
            load_cnt_reg <= '0;
            ready_reg    <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            scale_reg    <= '0;
            ow_reg       <= '0;
            oh_reg       <= '0;
        end else if (cfg_we && cfg_addr <= CFG_FIT_MODE) begin
            case (cfg_addr)
                CFG_SRC_WIDTH:  width_reg  <= cfg_data;
                CFG_SRC_HEIGHT: height_reg <= cfg_data;
                CFG_CHANNELS:   chan_reg   <= cfg_data[2:0];
                CFG_LIMIT_X:    limx_reg   <= cfg_data;
                CFG_LIMIT_Y:    limy_reg   <= cfg_data;
                CFG_FIT_MODE:   cover_reg  <= cfg_data[0];
                default: ;
            endcase
            load_cnt_reg <= '0;
            ready_reg    <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            scale_reg    <= '0;
            ow_reg       <= '0;
            oh_reg       <= '0;
        end else begin
            if (cmd.load_we) begin
                load_cnt_reg <= load_cnt_reg + 1'b1;
            end
            if (dv_done_reg) begin
                case (dv_op_reg)
                    DIV_RX: rx_reg <= dv_quo_reg;
                    DIV_RY: scale_reg <= sel_s;
                    DIV_OW: ow_reg <= q_clamp;
                    DIV_OH: begin
                        oh_reg    <= q_clamp;
                        ready_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (cmd.out_load && st == ST_PIXEL) begin
                if (DIM_W'(col_reg) + 1'b1 >= ow_reg) begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_tuser <= st;
            if (st == ST_PIXEL) begin
                m_tdata <= {6'd0, oh_reg, ow_reg, row_reg[POS_W-1:0], col_reg,
                            (chan_reg == 3'd3) ? {8'd0, rd_data_reg[23:0]} : rd_data_reg};
                m_tlast <= last;
            end else begin
                m_tdata <= '0;
                m_tlast <= 1'b0;
            end
        end
    end
    assign m_tvalid = out_valid_reg;
endmodule
`default_nettype wire

FILE: design/afns_ctrl.sv
// controller: load, scale computation sequence and read timing
`default_nettype none
module afns_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic                 s_tuser,
    input  wire afns_pkg::afns_stat_t stat,
    output afns_pkg::afns_cmd_t       cmd
);
    import afns_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DIV_GO, S_DIV_WAIT, S_READ, S_OUT} state_t;

    state_t     state_reg, state_next;
    div_op_t    op_reg, op_next;
    logic [1:0] wait_reg, wait_next;
    logic       acc;

    assign s_tready = (state_reg == S_IDLE);
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        wait_next     = wait_reg;
        cmd.load_we   = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_op    = op_reg;
        cmd.out_load  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (acc && s_tuser == OP_LOAD) begin
                    cmd.load_we = stat.geom_ok && !stat.frame_ready && stat.load_room;
                    if (cmd.load_we && stat.load_last) begin
                        state_next = S_DIV_GO;
                        op_next    = DIV_RX;
                    end
                end else if (acc) begin
                    state_next = S_READ;
                    wait_next  = 2'd3;
                end
            end
            S_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (stat.div_done) begin
                    if (op_reg == DIV_OH) begin
                        state_next = S_IDLE;
                    end else begin
                        op_next    = div_op_t'(op_reg + 1'b1);
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_READ: begin
                wait_next = wait_reg - 1'b1;
                if (wait_reg == 2'd0) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= DIV_RX;
            wait_reg  <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            wait_reg  <= wait_next;
        end
    end

    a_load_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_we |-> stat.geom_ok && !stat.frame_ready)
        else $error("load written outside an open frame");
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> !stat.div_done)
        else $error("divider finished too early");
    a_out_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> state_reg == S_IDLE && !cmd.div_start)
        else $error("controller not idle after result");
endmodule
`default_nettype wire

FILE: design/aspect_fit_nearest_scaler_top.sv
// top level of the aspect-preserving nearest-neighbour image scaler
// an accepted load request writes its pixel into the open frame; a read request raises m_tvalid
//   after passing the partial-product, clamp, address, store read and result register stages
// throughput: one load per cycle while idle; a read blocks new requests until its result is loaded
// the last load of a frame starts four 32-step divisions, during which no request is taken
// reset: synchronous active-low aresetn restores register defaults and empties the frame
`default_nettype none
module aspect_fit_nearest_scaler_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [12:0] cfg_data,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // pixel_in
    input  wire logic        s_tuser,   // operation: 0 load, 1 read
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // pixel_out, out_col, out_row, scaled_width, scaled_height
    output logic             m_tlast,   // last_pixel
    output logic [1:0]       m_tuser    // status
);
    import afns_pkg::*;

    afns_cmd_t  cmd;
    afns_stat_t stat;

    // sequencing of loads, the scale divisions and reads
    afns_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // frame store, divider, coordinate pipeline and result register
    afns_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .pixel_in (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );
endmodule
`default_nettype wire
